### rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants and helpers for the integer-to-ASCII radix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int DIGIT_DEPTH_DEFAULT = 32;

   // Longest text for one number, the minus sign included.
   localparam int MAX_CHARS = 32;

   localparam int RADIX_WIDTH = 6;
   localparam int CHAR_WIDTH  = 7;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] DECIMAL     = 6'd10;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] ASCII_A     = 7'h41;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 7'h2D;

   // Digits below ten map to '0'..'9', the rest to 'A'..'Z'.
   function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [RADIX_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] wide_d;
      wide_d = CHAR_WIDTH'(d);
      if (d < DECIMAL) begin
         return ASCII_ZERO + wide_d;
      end
      return ASCII_A + wide_d - CHAR_WIDTH'(DECIMAL);
   endfunction

endpackage

`default_nettype wire

### rtl/itoa_ram.sv
// ----------------------------------------------------------------------------
// itoa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/itoa_div.sv
// ----------------------------------------------------------------------------
// itoa_div
// Bit-serial restoring divider: one quotient bit per cycle by a small radix.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_div #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               load,
   input  wire logic [VALUE_WIDTH-1:0]             dividend,
   input  wire logic [itoa_pkg::RADIX_WIDTH-1:0]   divisor,
   output logic                                    done,
   output logic      [VALUE_WIDTH-1:0]             quotient,
   output logic      [itoa_pkg::RADIX_WIDTH-1:0]   remainder
);

   import itoa_pkg::*;

   localparam int CNT_WIDTH = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   // The dividend shifts out of the top of quo_ff while quotient bits enter
   // at the bottom; after VALUE_WIDTH steps the register holds the quotient.
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [RADIX_WIDTH-1:0] rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0] div_ff, div_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;

   logic [RADIX_WIDTH:0]   trial;
   logic [RADIX_WIDTH:0]   diff;
   logic                   fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff    = trial - {1'b0, div_ff};
      fits    = trial >= {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CNT_WIDTH'(VALUE_WIDTH - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in = fits ? diff[RADIX_WIDTH-1:0] : trial[RADIX_WIDTH-1:0];
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/integer_to_ascii_radix_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core
// Converts an integer (signed in base ten) to its ASCII text in a base from 2 to 36,
// most significant digit first, one character word per strobe.
// ----------------------------------------------------------------------------
// Each digit passes the load and divide states in the bit-serial divider and
// the read and data states to be read back; a leading minus is sent in the
// first read state and adds no state of its own.
// The last character word shows in the cycle in which busy first reads low,
// and a start in that cycle is taken. The receiver cannot stall.
// Synchronous reset returns to idle and sets the radix register to ten.
`default_nettype none

module integer_to_ascii_radix_core #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DIGIT_DEPTH = itoa_pkg::DIGIT_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input word: one integer per accepted start.
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [VALUE_WIDTH-1:0]     req_number,
   // Result words: one character per strobe.
   output logic                                   rsp_valid,
   output logic      [itoa_pkg::CHAR_WIDTH-1:0]   rsp_character,
   output logic                                   rsp_last,
   // Radix register.
   input  wire logic                              csr_we,
   input  wire logic [itoa_pkg::RADIX_WIDTH-1:0]  csr_wdata
);

   import itoa_pkg::*;

   localparam int ADDR_WIDTH  = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DIGIT_DEPTH + 1);

   // Digit limit: the store depth, but never more digits than fit in the
   // character budget, which shrinks by one when a minus sign leads.
   localparam int LIMIT_PLAIN = (DIGIT_DEPTH < MAX_CHARS) ? DIGIT_DEPTH : MAX_CHARS;
   localparam int LIMIT_MINUS = (DIGIT_DEPTH < MAX_CHARS - 1) ? DIGIT_DEPTH : MAX_CHARS - 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_READ,
      ST_DATA
   } state_type;

   state_type              state_ff, state_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic [RADIX_WIDTH-1:0] base_ff, base_in;
   logic                   minus_ff, minus_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [RADIX_WIDTH-1:0] base_clamped;
   logic [VALUE_WIDTH-1:0] value_bits;
   logic                   value_neg;
   logic                   take_minus;
   logic [COUNT_WIDTH-1:0] count_next;
   logic [COUNT_WIDTH-1:0] limit;

   logic                   div_load;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [RADIX_WIDTH-1:0] div_remainder;

   logic                   ram_we;
   logic [ADDR_WIDTH-1:0]  ram_wr_addr;
   logic [ADDR_WIDTH-1:0]  ram_rd_addr;
   logic [RADIX_WIDTH-1:0] ram_rd_data;

   // Out-of-range radix settings are pinned to the nearest legal base.
   always_comb begin
      if (radix_ff inside {[RADIX_MIN:RADIX_MAX]}) begin
         base_clamped = radix_ff;
      end else if (radix_ff < RADIX_MIN) begin
         base_clamped = RADIX_MIN;
      end else begin
         base_clamped = RADIX_MAX;
      end
   end

   assign value_bits = $unsigned(req_number);
   assign value_neg  = value_bits[VALUE_WIDTH-1];
   // Only decimal text carries a sign; other bases read the bits as unsigned.
   assign take_minus = value_neg && (base_clamped == DECIMAL);

   assign count_next  = count_ff + COUNT_WIDTH'(1);
   assign limit       = minus_ff ? COUNT_WIDTH'(LIMIT_MINUS) : COUNT_WIDTH'(LIMIT_PLAIN);
   assign ram_wr_addr = count_ff[ADDR_WIDTH-1:0];
   assign ram_rd_addr = count_next[ADDR_WIDTH-1:0] - ADDR_WIDTH'(2);

   // The conversion runs in two phases. First the divider peels digits off
   // the magnitude, least significant first, and each remainder is written
   // to the digit RAM. Then the RAM is read back from the top down, so the
   // text comes out most significant digit first. A leading minus sign is
   // sent in the first read cycle, while the RAM fetches the top digit.
   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      base_in      = base_ff;
      minus_in     = minus_ff;
      mag_in       = mag_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      div_load     = 1'b0;
      ram_we       = 1'b0;

      if (csr_we) begin
         radix_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               base_in  = base_clamped;
               minus_in = take_minus;
               mag_in   = take_minus ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;
               count_in = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            div_load = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               // Store this digit and keep dividing while a nonzero
               // quotient is left and the digit budget allows another.
               ram_we   = 1'b1;
               count_in = count_next;
               mag_in   = div_quotient;
               if ((div_quotient != '0) && (count_next < limit)) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // The RAM address is count - 1; the digit is ready next cycle.
            rsp_valid_in = minus_ff;
            rsp_char_in  = ASCII_MINUS;
            rsp_last_in  = 1'b0;
            minus_in     = 1'b0;
            count_in     = count_ff - COUNT_WIDTH'(1);
            state_in     = ST_DATA;
         end
         ST_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = digit_to_ascii(ram_rd_data);
            rsp_last_in  = (count_ff == '0);
            state_in     = (count_ff == '0) ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      mag_ff      <= mag_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         minus_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         minus_ff     <= minus_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   itoa_div #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .load      (div_load),
      .dividend  (mag_ff),
      .divisor   (base_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   itoa_ram #(
      .WIDTH (RADIX_WIDTH),
      .DEPTH (DIGIT_DEPTH)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (div_remainder),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire
